// File: hdl/lscd_pkg.sv
// Shared types, constants and microcode program of the change dispenser
`timescale 1ns / 1ps
package lscd_pkg;

  localparam int NUM_NOTES = 7;
  localparam int NUM_COINS = 3;
  localparam int NUM_SLOTS = NUM_NOTES + NUM_COINS;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam int CNT_W      = 8;
  localparam int AMT_W      = 16;
  localparam int VAL_W      = 11;
  localparam int PROD_W     = VAL_W + CNT_W + 1;
  localparam int RECIP_W    = 28;
  localparam int RECIP_SH   = 27;
  localparam int MUL_W      = AMT_W + RECIP_W;
  localparam int IDX_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int ADDR_W     = 3;
  localparam int APB_W      = 32;
  localparam int PC_W       = 4;

  localparam logic [CNT_W-1:0] NOTE_STOCK_RST = 8'd2;
  localparam logic [CNT_W-1:0] COIN_STOCK_RST = 8'd5;
  localparam logic [CNT_W-1:0] NOTE_LEVEL_RST = 8'd5;
  localparam logic [CNT_W-1:0] COIN_LEVEL_RST = 8'd10;

  // register select is paddr[2]
  localparam logic REG_NOTE_LEVEL = 1'b0;
  localparam logic REG_COIN_LEVEL = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DISPENSED   = 2'd0,
    ST_NO_CHANGE   = 2'd1,
    ST_NOTHING_DUE = 2'd2,
    ST_REFILLED    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ACT_WAIT,
    ACT_NOP,
    ACT_INIT,
    ACT_DIV,
    ACT_SLOT_END,
    ACT_SCAN_INIT,
    ACT_EMIT,
    ACT_REFILL,
    ACT_ZERO,
    ACT_FAIL
  } act_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_NO_ACCEPT,
    JMP_REFILL_OP,
    JMP_AMOUNT_ZERO,
    JMP_SLOT_NLAST,
    JMP_REM_NZ
  } jmp_t;

  typedef struct packed {
    act_t            act;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV    = 4'd4;
  localparam logic [PC_W-1:0] PC_EMIT   = 4'd8;
  localparam logic [PC_W-1:0] PC_REFILL = 4'd10;
  localparam logic [PC_W-1:0] PC_ZERO   = 4'd11;
  localparam logic [PC_W-1:0] PC_FAIL   = 4'd12;

  // Control store: one word per step
  function automatic uword_t microcode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{ACT_WAIT,      JMP_NO_ACCEPT,   PC_IDLE};
      4'd1:    w = '{ACT_NOP,       JMP_REFILL_OP,   PC_REFILL};
      4'd2:    w = '{ACT_NOP,       JMP_AMOUNT_ZERO, PC_ZERO};
      4'd3:    w = '{ACT_INIT,      JMP_NEXT,        PC_IDLE};
      4'd4:    w = '{ACT_DIV,       JMP_NEXT,        PC_IDLE};
      4'd5:    w = '{ACT_SLOT_END,  JMP_SLOT_NLAST,  PC_DIV};
      4'd6:    w = '{ACT_NOP,       JMP_REM_NZ,      PC_FAIL};
      4'd7:    w = '{ACT_SCAN_INIT, JMP_NEXT,        PC_IDLE};
      4'd8:    w = '{ACT_EMIT,      JMP_SLOT_NLAST,  PC_EMIT};
      4'd9:    w = '{ACT_NOP,       JMP_ALWAYS,      PC_IDLE};
      4'd10:   w = '{ACT_REFILL,    JMP_ALWAYS,      PC_IDLE};
      4'd11:   w = '{ACT_ZERO,      JMP_ALWAYS,      PC_IDLE};
      4'd12:   w = '{ACT_FAIL,      JMP_ALWAYS,      PC_IDLE};
      default: w = '{ACT_NOP,       JMP_ALWAYS,      PC_IDLE};
    endcase
    return w;
  endfunction

  // Face value of a slot; slots beyond the known values are worth nothing
  function automatic logic [VAL_W-1:0] slot_value(input logic [SLOT_W-1:0] slot);
    int s;
    int v;
    s = int'(slot);
    v = 0;
    if (s < NUM_NOTES) begin
      case (s)
        0:       v = 2000;
        1:       v = 500;
        2:       v = 200;
        3:       v = 100;
        4:       v = 50;
        5:       v = 20;
        6:       v = 10;
        default: v = 0;
      endcase
    end else begin
      case (s - NUM_NOTES)
        0:       v = 5;
        1:       v = 2;
        2:       v = 1;
        default: v = 0;
      endcase
    end
    return VAL_W'(v);
  endfunction

  // Scaled reciprocal ceil(2^27 / value) of a slot, zero where the slot has no value.
  // (amount * reciprocal) >> 27 is the exact quotient for any 16-bit amount.
  function automatic logic [RECIP_W-1:0] slot_recip(input logic [SLOT_W-1:0] slot);
    int s;
    int r;
    s = int'(slot);
    r = 0;
    if (s < NUM_NOTES) begin
      case (s)
        0:       r = 67109;
        1:       r = 268436;
        2:       r = 671089;
        3:       r = 1342178;
        4:       r = 2684355;
        5:       r = 6710887;
        6:       r = 13421773;
        default: r = 0;
      endcase
    end else begin
      case (s - NUM_NOTES)
        0:       r = 26843546;
        1:       r = 67108864;
        2:       r = 134217728;
        default: r = 0;
      endcase
    end
    return RECIP_W'(r);
  endfunction

endpackage

// File: hdl/limited_stock_change_dispenser.sv
// Top level of the change dispenser: microcoded sequencer and datapath
`timescale 1ns / 1ps
// After the input transfer, a refill passes the operation check and its refill step loads
// the result; nothing due also passes the amount check, then its zero step loads the result;
// a dispense runs an init step, a divide and a close step per slot and a remainder check
// (failing there if anything is left), then an emit step per slot, one result per used slot.
// One request at a time, the next taken once the sequencer is idle; back-pressure holds steps.
// Reset (rst, synchronous, active high): sequencer idle, output empty, stocks 2/5, levels 5/10.
module limited_stock_change_dispenser (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lscd_pkg::IN_DATA_W-1:0] s_tdata,   // [15:0] amount
  input  logic                           s_tuser,   // [0] operation
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lscd_pkg::OUT_DATA_W-1:0] m_tdata,  // [3:0] denomination_index,
                                                     // [11:4] piece_count, [15:12] zero
  output logic [lscd_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
  output logic                           m_tlast,   // last
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lscd_pkg::ADDR_W-1:0]    paddr,
  input  logic [lscd_pkg::APB_W-1:0]     pwdata,
  output logic [lscd_pkg::APB_W-1:0]     prdata,
  output logic                           pready
);
  import lscd_pkg::*;

  // sequencer
  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_next;
  uword_t            uw;
  logic              take_jump;
  logic              stall;
  logic              emits;
  logic              fire;

  // request latched at the transfer
  logic              op_refill;
  logic [AMT_W-1:0]  amount;

  // datapath
  logic [AMT_W-1:0]  rem;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] last_slot;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  stock [NUM_SLOTS];
  logic [CNT_W-1:0]  take  [NUM_SLOTS];

  logic [CNT_W-1:0]  note_level;
  logic [CNT_W-1:0]  coin_level;

  // output register
  logic              out_valid;
  status_t           out_status;
  logic [IDX_W-1:0]  out_idx;
  logic [CNT_W-1:0]  out_count;
  logic              out_last;

  // combinational helpers
  logic [VAL_W-1:0]   cur_val;
  logic [RECIP_W-1:0] cur_recip;
  logic [CNT_W-1:0]   cur_stock;
  logic [CNT_W-1:0]   cur_take;
  logic               slot_is_last;
  logic               out_free;
  logic               in_xfer;
  logic [MUL_W-1:0]   quo_prod;
  logic [AMT_W-1:0]   quo;
  logic [CNT_W-1:0]   cur_n;
  logic [PROD_W-1:0]  prod;
  logic               cfg_wr;

  always_comb begin
    uw           = microcode(pc);
    cur_val      = slot_value(slot);
    cur_recip    = slot_recip(slot);
    cur_stock    = stock[slot];
    cur_take     = take[slot];
    slot_is_last = (slot == SLOT_W'(NUM_SLOTS - 1));
    out_free     = !out_valid || m_tready;
    in_xfer      = s_tvalid && s_tready;
    // rem / value by reciprocal multiplication, capped at the stock on hand
    quo_prod = MUL_W'(rem) * MUL_W'(cur_recip);
    quo      = quo_prod[RECIP_SH +: AMT_W];
    cur_n    = (quo > AMT_W'(cur_stock)) ? cur_stock : quo[CNT_W-1:0];
    // value of the pieces taken from the current slot
    prod     = PROD_W'(n) * PROD_W'(cur_val);

    emits = (uw.act == ACT_REFILL) || (uw.act == ACT_ZERO) || (uw.act == ACT_FAIL) ||
            ((uw.act == ACT_EMIT) && (cur_take != '0));
    // hold the step while a result cannot be written into the output register
    stall = emits && !out_free;
    fire  = emits && out_free;

    case (uw.jmp)
      JMP_NEXT:        take_jump = 1'b0;
      JMP_ALWAYS:      take_jump = 1'b1;
      JMP_NO_ACCEPT:   take_jump = !in_xfer;
      JMP_REFILL_OP:   take_jump = op_refill;
      JMP_AMOUNT_ZERO: take_jump = (amount == '0);
      JMP_SLOT_NLAST:  take_jump = !slot_is_last;
      JMP_REM_NZ:      take_jump = (rem != '0);
      default:         take_jump = 1'b0;
    endcase

    if (stall) begin
      pc_next = pc;
    end else if (take_jump) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  assign s_tready = (uw.act == ACT_WAIT);
  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = OUT_DATA_W'({out_count, out_idx});

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_COIN_LEVEL) ? APB_W'(coin_level) : APB_W'(note_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= PC_IDLE;
      out_valid  <= 1'b0;
      slot       <= '0;
      note_level <= NOTE_LEVEL_RST;
      coin_level <= COIN_LEVEL_RST;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        stock[i] <= (i < NUM_NOTES) ? NOTE_STOCK_RST : COIN_STOCK_RST;
      end
    end else begin
      pc <= pc_next;

      // load a new result, else drop the held one once it is taken
      out_valid <= fire || (out_valid && !m_tready);

      if (cfg_wr) begin
        if (paddr[2] == REG_NOTE_LEVEL) begin
          note_level <= pwdata[CNT_W-1:0];
        end else begin
          coin_level <= pwdata[CNT_W-1:0];
        end
      end

      case (uw.act)
        ACT_WAIT: begin
          if (in_xfer) begin
            op_refill <= s_tuser;
            amount    <= s_tdata[AMT_W-1:0];
          end
        end
        ACT_INIT: begin
          rem  <= amount;
          slot <= '0;
        end
        ACT_DIV: begin
          n <= cur_n;
        end
        ACT_SLOT_END: begin
          // close the slot: keep its count, take its value off the remainder
          take[slot] <= n;
          rem        <= rem - prod[AMT_W-1:0];
          if (n != '0) begin
            last_slot <= slot;
          end
          slot <= slot_is_last ? '0 : slot + SLOT_W'(1);
        end
        ACT_SCAN_INIT: begin
          slot <= '0;
        end
        ACT_EMIT: begin
          if (!stall) begin
            if (cur_take != '0) begin
              out_status  <= ST_DISPENSED;
              out_idx     <= IDX_W'(slot);
              out_count   <= cur_take;
              out_last    <= (slot == last_slot);
              stock[slot] <= cur_stock - cur_take;
            end
            slot <= slot_is_last ? '0 : slot + SLOT_W'(1);
          end
        end
        ACT_REFILL: begin
          if (!stall) begin
            out_status <= ST_REFILLED;
            out_idx    <= '0;
            out_count  <= '0;
            out_last   <= 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              stock[i] <= (i < NUM_NOTES) ? note_level : coin_level;
            end
          end
        end
        ACT_ZERO: begin
          if (!stall) begin
            out_status <= ST_NOTHING_DUE;
            out_idx    <= '0;
            out_count  <= '0;
            out_last   <= 1'b1;
          end
        end
        ACT_FAIL: begin
          if (!stall) begin
            out_status <= ST_NO_CHANGE;
            out_idx    <= '0;
            out_count  <= '0;
            out_last   <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hdl/lscd_checker.sv
// Port-level checker for the change dispenser and its bind
`timescale 1ns / 1ps
module lscd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lscd_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [lscd_pkg::STATUS_W-1:0]   m_tuser,
  input logic                            m_tlast
);
  import lscd_pkg::*;

  // output register empties on reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // one request at a time: busy right after a transfer in
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  // single-result outcomes are last and carry no pieces
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_DISPENSED) |-> m_tlast && (m_tdata == '0))
    else $error("malformed status-only result");

  // a dispensed result always hands out pieces
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_DISPENSED) |-> (m_tdata[11:4] != '0))
    else $error("dispensed result with no pieces");

endmodule

bind limited_stock_change_dispenser lscd_checker u_lscd_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for the limited-stock change dispenser
`timescale 1ns / 1ps
module tb_top;

  localparam int NSLOT = lscd_pkg::NUM_SLOTS;

  // One expected result: what the dispenser should hand out next
  typedef struct packed {
    lscd_pkg::status_t status;
    logic [3:0]        slot;
    logic [7:0]        pieces;
    logic              final_piece;
  } payout_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [lscd_pkg::IN_DATA_W-1:0]    s_tdata;   // [15:0] amount
  logic                              s_tuser;   // [0] operation
  logic                              m_tvalid;
  logic                              m_tready;
  logic [lscd_pkg::OUT_DATA_W-1:0]   m_tdata;   // [3:0] slot, [11:4] pieces, [15:12] zero
  logic [lscd_pkg::STATUS_W-1:0]     m_tuser;   // [1:0] status
  logic                              m_tlast;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [lscd_pkg::ADDR_W-1:0]       paddr;
  logic [lscd_pkg::APB_W-1:0]        pwdata;
  logic [lscd_pkg::APB_W-1:0]        prdata;
  logic                              pready;

  // Shadow of the dispenser: stock per slot and the two refill levels
  logic [7:0] stock_on_hand [NSLOT];
  logic [7:0] note_level;
  logic [7:0] coin_level;

  // Results still owed by the dispenser, oldest first
  payout_t change_due [$];

  int  fail_count = 0;
  int  hold_left  = 0;   // long receiver hold-off, counted down by the collector
  int  stall_left = 0;   // current random receiver stall burst
  bit  calm       = 1'b0; // no idling on either side while set

  always #5 clk = ~clk;

  limited_stock_change_dispenser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Face value of each slot: seven notes largest first, then three coins
  function automatic int unsigned face_value(input int slot);
    case (slot)
      0:       return 2000;
      1:       return 500;
      2:       return 200;
      3:       return 100;
      4:       return 50;
      5:       return 20;
      6:       return 10;
      7:       return 5;
      8:       return 2;
      9:       return 1;
      default: return 0;
    endcase
  endfunction

  // Work out the change for one accepted request and queue the results.
  // A single greedy pass is enough: the stock does not move until the
  // remainder is known to reach zero.
  task automatic work_out_change(input logic refill, input logic [15:0] amount);
    int unsigned left;
    int unsigned take [NSLOT];
    int unsigned value;
    int          last_used;
    payout_t     p;
    p = '{status: lscd_pkg::ST_DISPENSED, slot: 4'd0, pieces: 8'd0, final_piece: 1'b1};
    if (refill) begin
      for (int i = 0; i < NSLOT; i++)
        stock_on_hand[i] = (i < lscd_pkg::NUM_NOTES) ? note_level : coin_level;
      p.status = lscd_pkg::ST_REFILLED;
      change_due.push_back(p);
      return;
    end
    if (amount == 16'd0) begin
      p.status = lscd_pkg::ST_NOTHING_DUE;
      change_due.push_back(p);
      return;
    end
    left      = amount;
    last_used = -1;
    for (int i = 0; i < NSLOT; i++) begin
      value   = face_value(i);
      take[i] = 0;
      if (value != 0) begin
        take[i] = left / value;
        if (take[i] > stock_on_hand[i]) take[i] = stock_on_hand[i];
      end
      if (take[i] > 0) begin
        left      = left - take[i] * value;
        last_used = i;
      end
    end
    if (left != 0) begin
      p.status = lscd_pkg::ST_NO_CHANGE;
      change_due.push_back(p);
      return;
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (take[i] > 0) begin
        stock_on_hand[i] = stock_on_hand[i] - 8'(take[i]);
        p.status      = lscd_pkg::ST_DISPENSED;
        p.slot        = 4'(i);
        p.pieces      = 8'(take[i]);
        p.final_piece = (i == last_used);
        change_due.push_back(p);
      end
    end
  endtask

  // Collector: check every result transfer against the oldest expectation,
  // then decide whether to take the next one
  always @(posedge clk) begin : collector
    payout_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (change_due.size() == 0) begin
        $error("unexpected result: status %0d slot %0d pieces %0d last %0d",
               m_tuser, m_tdata[3:0], m_tdata[11:4], m_tlast);
        fail_count++;
      end else begin
        want = change_due.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          fail_count++;
        end
        if (m_tdata[3:0] !== want.slot) begin
          $error("denomination_index: expected %0d, got %0d", want.slot, m_tdata[3:0]);
          fail_count++;
        end
        if (m_tdata[11:4] !== want.pieces) begin
          $error("piece_count: expected %0d, got %0d", want.pieces, m_tdata[11:4]);
          fail_count++;
        end
        if (m_tlast !== want.final_piece) begin
          $error("last: expected %0d, got %0d", want.final_piece, m_tlast);
          fail_count++;
        end
      end
    end
    // Hold off for the long stretch first, then random stall bursts
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offer one request, sometimes after a random gap, and predict on transfer.
  // tvalid stays high afterwards so back-to-back requests need no re-raise.
  task automatic offer_request(input logic refill, input logic [15:0] amount);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= refill;
    s_tdata  <= amount;
    do @(posedge clk); while (!s_tready);
    work_out_change(refill, amount);
  endtask

  // Pause the sender until every owed result has arrived, then let the
  // sequencer settle back to idle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (change_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write one refill level over the configuration port and read it back
  task automatic set_refill_level(input logic which, input logic [7:0] level);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= {24'($urandom()), level};   // upper bits must be dropped
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (which == lscd_pkg::REG_NOTE_LEVEL) note_level = level;
    else                                   coin_level = level;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== {24'd0, level}) begin
      $error("refill level read-back: expected %0d, got %0d", level, got);
      fail_count++;
    end
  endtask

  task automatic set_levels(input logic [7:0] notes, input logic [7:0] coins);
    wait_drained();
    set_refill_level(lscd_pkg::REG_NOTE_LEVEL, notes);
    set_refill_level(lscd_pkg::REG_COIN_LEVEL, coins);
  endtask

  // Mostly well-formed change requests of varied size, some refills
  task automatic random_request();
    logic [15:0] amount;
    int          pick;
    pick   = $urandom_range(0, 99);
    amount = 16'($urandom());
    if (pick < 12) begin
      offer_request(1'b1, amount);
    end else begin
      if (pick < 50)      amount = 16'($urandom_range(0, 200));
      else if (pick < 72) amount = 16'($urandom_range(0, 3000));
      else if (pick < 85) amount = 16'(5 * $urandom_range(0, 2000));
      offer_request(1'b0, amount);
    end
  endtask

  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(1, 30));
    endcase
  endfunction

  // Reset stock: nothing due, fail, empty the whole stock, fail on it, then refill and dispense
  task automatic test_reset_stock();
    offer_request(1'b0, 16'd0);
    offer_request(1'b0, 16'd65535);   // far more than the stock holds
    offer_request(1'b0, 16'd5800);    // every slot, every piece
    offer_request(1'b0, 16'd1);       // stock now empty
    offer_request(1'b1, 16'hFFFF);    // refill to the reset levels
    offer_request(1'b0, 16'd1);
    offer_request(1'b0, 16'd8);
    offer_request(1'b0, 16'd2888);
  endtask

  // Refill level extremes, each read back over the configuration port
  task automatic test_refill_levels();
    set_levels(8'd0, 8'd255);
    offer_request(1'b1, 16'd0);
    offer_request(1'b0, 16'd2040);    // 255 pieces from each coin slot
    offer_request(1'b0, 16'd3);       // coins gone, no notes
    set_levels(8'd255, 8'd255);
    offer_request(1'b1, 16'd0);
    offer_request(1'b0, 16'd65535);
    offer_request(1'b0, 16'd65535);
    set_levels(8'd0, 8'd0);
    offer_request(1'b1, 16'd0);
    offer_request(1'b0, 16'd1);
    offer_request(1'b0, 16'd0);
  endtask

  // Hold the result side off while requests keep coming, so the input stalls
  task automatic test_output_hold();
    set_levels(8'd20, 8'd40);
    hold_left = 400;
    offer_request(1'b1, 16'd0);
    repeat (8) random_request();
  endtask

  // Random requests in phases, with fresh refill levels between them
  task automatic test_random_mix();
    for (int phase = 0; phase < 5; phase++) begin
      set_levels(random_level(), random_level());
      calm = (phase == 2);
      offer_request(1'b1, 16'($urandom()));
      repeat (80) random_request();
    end
    calm = 1'b0;
  endtask

  // Last stretch: no idling on either side
  task automatic test_steady_stream();
    set_levels(8'd5, 8'd10);
    calm = 1'b1;
    offer_request(1'b1, 16'd0);
    repeat (30) random_request();
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    for (int i = 0; i < NSLOT; i++)
      stock_on_hand[i] = (i < lscd_pkg::NUM_NOTES) ? lscd_pkg::NOTE_STOCK_RST
                                                   : lscd_pkg::COIN_STOCK_RST;
    note_level = lscd_pkg::NOTE_LEVEL_RST;
    coin_level = lscd_pkg::COIN_LEVEL_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_stock();
    test_refill_levels();
    test_output_hold();
    test_random_mix();
    test_steady_stream();

    // Drain, then watch a while longer for any stray result
    wait_drained();
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
